FILE: sv/assert_macros.svh
// Assertion helpers used by the top-level matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property at every rising clock edge outside reset.
`define ASSERT_CHK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CHK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

FILE: sv/sdtw_pkg.sv
`timescale 1ns / 1ps
package sdtw_pkg;

    localparam int DEF_WINDOW      = 21;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int COST_W      = 40;
    localparam int ROOT_W      = 20;
    localparam int BAND_W      = 5;
    localparam int OUT_TDATA_W = 64;

    localparam logic [BAND_W-1:0] BAND_RESET = BAND_W'(21);
    localparam logic [COST_W-1:0] COST_MAX   = '1;

    // Sequencer states of the top level.
    typedef enum logic [4:0] {
        S_IDLE,
        S_TRD,
        S_TWR,
        S_FILL,
        S_RRD,
        S_RWR,
        S_MA_GO,
        S_MA_WAIT,
        S_MB_GO,
        S_MB_WAIT,
        S_GRID,
        S_GAP1,
        S_GAP2,
        S_FIN,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_OUT
    } t_state;

    // Per-cell control that travels with a grid cell down the cost pipeline.
    typedef struct packed {
        logic vld;
        logic row0;
        logic diag_ok;
        logic up_ok;
        logic left_ok;
    } t_cell_ctl;

endpackage

FILE: sv/sliding_window_dtw_matcher.sv
`timescale 1ns / 1ps
// One item is handled at a time; within a row the cost pipeline retires one grid cell per cycle.
// Reset (synchronous, active low) empties the ring, zeroes the template and sets band to 21.
`include "assert_macros.svh"
module sliding_window_dtw_matcher #(
    parameter int WINDOW      = sdtw_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = sdtw_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // Input stream. tdata: sample (SAMPLE_BITS, signed), zero padded to whole bytes.
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]  s_axis_tdata,
    // tuser: op (1 bit), 0 loads a template sample, 1 pushes a test sample.
    input  logic                                      s_axis_tuser,
    // Result stream. tdata: distance_sq [39:0], distance_root [59:40], zeros above.
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    output logic [sdtw_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    // Band half-width register write channel.
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [sdtw_pkg::BAND_W-1:0]               i_cfg_data
);
    import sdtw_pkg::*;

    localparam int AW    = $clog2(WINDOW);
    localparam int IW    = $clog2(WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW) + 1;
    localparam int CW    = ((IW > BAND_W) ? IW : BAND_W) + 2;

    // The sequencer walks each item through a fixed order of steps. A push into a full ring
    // swaps the oldest sample, derives both means with the shared reciprocal divider, sweeps
    // the band row by row through the cell pipeline and hands the cost to the serial root unit.

    t_state r_state, n_state;

    logic                          r_op;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [BAND_W-1:0]             r_band;

    // Template store: every entry has a valid bit, and an entry never loaded reads as zero.
    logic signed [SAMPLE_BITS-1:0] r_tmem [0:WINDOW-1];
    logic [WINDOW-1:0]             r_tvld;
    logic signed [SAMPLE_BITS-1:0] r_tq;
    logic                          r_tok;
    logic [AW-1:0]                 r_twi;
    logic signed [SUM_W-1:0]       r_tsum;

    // Test sample ring. It is only read once full, so it needs no valid bits.
    logic signed [SAMPLE_BITS-1:0] r_rmem [0:WINDOW-1];
    logic signed [SAMPLE_BITS-1:0] r_rq;
    logic [AW-1:0]                 r_head;
    logic [IW-1:0]                 r_fill;
    logic signed [SUM_W-1:0]       r_wsum;

    logic signed [SAMPLE_BITS-1:0] r_ma;
    logic signed [SAMPLE_BITS-1:0] r_mb;

    // Grid row and column of the cell being issued.
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_j, n_j;

    logic                   r_m_tvalid;
    logic [OUT_TDATA_W-1:0] r_m_tdata;

    logic                    s_acc;
    logic [AW-1:0]           t_raddr;
    logic [AW-1:0]           rg_raddr;
    logic [AW-1:0]           jm1;
    logic [AW:0]             rg_sum;
    logic [CW-1:0]           ie, je, we, lo_c, hi_c;
    t_cell_ctl               ctl;
    logic signed [SAMPLE_BITS-1:0] old_t;

    logic                    div_start;
    logic signed [SUM_W-1:0] div_in;
    logic                    div_done;
    logic signed [SUM_W-1:0] div_quot;

    logic [COST_W-1:0]       cost;
    logic                    root_start;
    logic                    root_done;
    logic [ROOT_W-1:0]       root;

    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

    // Memory addresses and the band limits of the current row.
    always_comb begin
        jm1    = AW'(r_j - IW'(1));
        rg_sum = {1'b0, r_head} + {1'b0, jm1};
        if (rg_sum >= (AW + 1)'(WINDOW)) begin
            rg_sum = rg_sum - (AW + 1)'(WINDOW);
        end
        t_raddr  = (r_state == S_TRD) ? r_twi : AW'(r_i - IW'(1));
        rg_raddr = (r_state == S_RRD) ? r_head : rg_sum[AW-1:0];

        ie   = CW'(r_i);
        je   = CW'(r_j);
        we   = CW'(r_band);
        lo_c = (ie > we + CW'(1)) ? ie - we : CW'(1);
        hi_c = (ie + we > CW'(WINDOW)) ? CW'(WINDOW) : ie + we;

        ctl.vld     = (r_state == S_GRID);
        ctl.row0    = (r_i == IW'(1));
        ctl.diag_ok = ctl.row0 ? (r_j == IW'(1)) : ((je >= CW'(2)) && (je + we >= ie));
        ctl.up_ok   = !ctl.row0 && (je + we + CW'(1) >= ie) && (je + CW'(1) <= ie + we);
        ctl.left_ok = (je != lo_c);

        old_t = r_tok ? r_tq : '0;
    end

    // Next state and the grid counters.
    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        div_start  = 1'b0;
        div_in     = r_tsum;
        root_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (!s_axis_tuser) begin
                        n_state = S_TRD;
                    end else if (r_fill == IW'(WINDOW)) begin
                        n_state = S_RRD;
                    end else begin
                        n_state = S_FILL;
                    end
                end
            end
            S_TRD:  n_state = S_TWR;
            S_TWR:  n_state = S_IDLE;
            S_FILL: n_state = (r_fill == IW'(WINDOW - 1)) ? S_MA_GO : S_IDLE;
            S_RRD:  n_state = S_RWR;
            S_RWR:  n_state = S_MA_GO;
            S_MA_GO: begin
                div_start = 1'b1;
                n_state   = S_MA_WAIT;
            end
            S_MA_WAIT: begin
                if (div_done) begin
                    n_state = S_MB_GO;
                end
            end
            S_MB_GO: begin
                div_start = 1'b1;
                div_in    = r_wsum;
                n_state   = S_MB_WAIT;
            end
            S_MB_WAIT: begin
                div_in = r_wsum;
                if (div_done) begin
                    n_i     = IW'(1);
                    n_j     = IW'(1);
                    n_state = S_GRID;
                end
            end
            S_GRID: begin
                if (je == hi_c) begin
                    n_state = S_GAP1;
                end else begin
                    n_j = r_j + IW'(1);
                end
            end
            // The idle states GAP1 and GAP2 let the last cell of a row reach the row memory.
            S_GAP1: begin
                if (r_i == IW'(WINDOW)) begin
                    n_state = S_FIN;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = S_GAP2;
                end
            end
            S_GAP2: begin
                n_j     = lo_c[IW-1:0];
                n_state = S_GRID;
            end
            S_FIN:  n_state = S_ROOT_GO;
            S_ROOT_GO: begin
                root_start = 1'b1;
                n_state    = S_ROOT_WAIT;
            end
            S_ROOT_WAIT: begin
                if (root_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_m_tvalid) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_band     <= BAND_RESET;
            r_tvld     <= '0;
            r_twi      <= '0;
            r_tsum     <= '0;
            r_head     <= '0;
            r_fill     <= '0;
            r_wsum     <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            if (i_cfg_valid && o_cfg_ready) begin
                r_band <= i_cfg_data;
            end
            case (r_state)
                S_TWR: begin
                    r_tsum        <= r_tsum + SUM_W'(r_sample) - SUM_W'(old_t);
                    r_tvld[r_twi] <= 1'b1;
                    r_twi         <= (r_twi == AW'(WINDOW - 1)) ? '0 : r_twi + AW'(1);
                end
                S_FILL: begin
                    r_wsum <= r_wsum + SUM_W'(r_sample);
                    r_fill <= r_fill + IW'(1);
                end
                S_RWR: begin
                    r_wsum <= r_wsum + SUM_W'(r_sample) - SUM_W'(r_rq);
                    r_head <= (r_head == AW'(WINDOW - 1)) ? '0 : r_head + AW'(1);
                end
                default: begin
                end
            endcase
            if (r_m_tvalid && m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end else if (r_state == S_OUT) begin
                r_m_tvalid <= 1'b1;
            end
        end
    end

    // Payload registers and the two sample memories.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_op     <= s_axis_tuser;
            r_sample <= $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
        end
        if (r_state == S_TWR && !r_op) begin
            r_tmem[r_twi] <= r_sample;
        end
        r_tq  <= r_tmem[t_raddr];
        r_tok <= r_tvld[t_raddr];
        if (r_state == S_FILL) begin
            r_rmem[r_fill[AW-1:0]] <= r_sample;
        end else if (r_state == S_RWR) begin
            r_rmem[r_head] <= r_sample;
        end
        r_rq <= r_rmem[rg_raddr];
        if (r_state == S_MA_WAIT && div_done) begin
            r_ma <= div_quot[SAMPLE_BITS-1:0];
        end
        if (r_state == S_MB_WAIT && div_done) begin
            r_mb <= div_quot[SAMPLE_BITS-1:0];
        end
        if (r_state == S_OUT && !r_m_tvalid) begin
            r_m_tdata <= {(OUT_TDATA_W - COST_W - ROOT_W)'(0), root, cost};
        end
    end

    // Mean of a series: signed sum over WINDOW, truncated toward zero.
    sdtw_div #(
        .DIVISOR (WINDOW),
        .N       (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_in),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    sdtw_cell #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_col   (r_j),
        .i_ta    (old_t),
        .i_rb    (r_rq),
        .i_ma    (r_ma),
        .i_mb    (r_mb),
        .o_cost  (cost)
    );

    sdtw_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_value (cost),
        .o_done  (root_done),
        .o_root  (root)
    );

    `ASSERT_CHK(a_fill_bound, i_clk, i_rst_n, r_fill <= IW'(WINDOW))
    `ASSERT_CHK(a_tmpl_seq, i_clk, i_rst_n, (s_acc && !s_axis_tuser) |=> ##2 (r_state == S_IDLE))
    `ASSERT_CHK(a_grid_col, i_clk, i_rst_n, (r_state == S_GRID) |-> (r_j >= IW'(1) && r_j <= IW'(WINDOW)))
    `ASSERT_NEVER(a_out_src, i_clk, i_rst_n, $rose(r_m_tvalid) && $past(r_state) != S_OUT)

endmodule

FILE: sv/sdtw_div.sv
`timescale 1ns / 1ps
module sdtw_div #(
    parameter int DIVISOR = sdtw_pkg::DEF_WINDOW,
    parameter int N       = 22
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [N-1:0] i_dividend,
    output logic                o_done,
    output logic signed [N-1:0] o_quot
);
    import sdtw_pkg::*;

    // The reciprocal is rounded up; its error times any magnitude up to 2^(N-1) stays below
    // 2^SH, so the shifted product is the exact floor quotient.
    localparam int SH = (N - 1) + $clog2(DIVISOR);
    localparam int MW = N + 1;
    localparam int PW = N + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic          r_mul;
    logic          r_done;
    logic          r_neg;
    logic [N-1:0]  r_mag;
    logic [PW-1:0] r_prod;

    logic [N-1:0]  quot_mag;

    // Magnitude times the reciprocal, then the sign is put back: truncation toward zero.
    always_comb begin
        quot_mag = N'(r_prod >> SH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_mul  <= i_start;
            r_done <= r_mul;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[N-1];
            r_mag <= i_dividend[N-1] ? N'(-i_dividend) : N'(i_dividend);
        end
        if (r_mul) begin
            r_prod <= PW'(r_mag) * PW'(RECIP);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(quot_mag) : $signed(quot_mag);

endmodule

FILE: sv/sdtw_isqrt.sv
`timescale 1ns / 1ps
module sdtw_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sdtw_pkg::COST_W-1:0]   i_value,
    output logic                          o_done,
    output logic [sdtw_pkg::ROOT_W-1:0]   o_root
);
    import sdtw_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [COST_W-1:0] r_x;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [ROOT_W+1:0] rem2;
    logic [ROOT_W+1:0] trial;
    logic              take;

    // Digit-by-digit root: while busy, two radicand bits enter and one root bit leaves per cycle.
    always_comb begin
        rem2  = {r_rem[ROOT_W-1:0], r_x[COST_W-1 -: 2]};
        trial = {r_root, 2'b01};
        take  = (rem2 >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[COST_W-3:0], 2'b00};
            r_rem  <= take ? rem2 - trial : rem2;
            r_root <= {r_root[ROOT_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: sv/sdtw_cell.sv
`timescale 1ns / 1ps
module sdtw_cell #(
    parameter int WINDOW      = sdtw_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = sdtw_pkg::DEF_SAMPLE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sdtw_pkg::t_cell_ctl               i_ctl,
    input  logic [$clog2(WINDOW + 1)-1:0]     i_col,
    input  logic signed [SAMPLE_BITS-1:0]     i_ta,
    input  logic signed [SAMPLE_BITS-1:0]     i_rb,
    input  logic signed [SAMPLE_BITS-1:0]     i_ma,
    input  logic signed [SAMPLE_BITS-1:0]     i_mb,
    output logic [sdtw_pkg::COST_W-1:0]       o_cost
);
    import sdtw_pkg::*;

    localparam int IW = $clog2(WINDOW + 1);
    localparam int DW = SAMPLE_BITS + 2;
    localparam int AD = SAMPLE_BITS + 1;
    localparam int PW = 2 * AD;
    localparam int ZW = (PW > COST_W) ? PW : COST_W;

    // Previous row of the cost grid, overwritten in place column by column.
    logic [COST_W-1:0] r_row [0:WINDOW];

    t_cell_ctl         r1_ctl;
    logic [IW-1:0]     r1_col;
    logic [COST_W-1:0] r1_diag;
    logic [COST_W-1:0] r1_up;

    t_cell_ctl         r2_ctl;
    logic [IW-1:0]     r2_col;
    logic [COST_W-1:0] r2_sq;
    logic [COST_W-1:0] r2_diag;
    logic [COST_W-1:0] r2_up;

    logic [COST_W-1:0] r_left;

    logic signed [DW-1:0] d;
    logic [AD-1:0]        ad;
    logic [PW-1:0]        prod;
    logic [ZW-1:0]        prod_z;
    logic [COST_W-1:0]    sq_sat;

    logic [COST_W-1:0] diag_v;
    logic [COST_W-1:0] best;
    logic              have;
    logic [COST_W:0]   sum;
    logic [COST_W-1:0] cost_new;

    // Stage one: mean-removed difference, its square, clamped to the cost range.
    always_comb begin
        d      = (DW'(i_ta) - DW'(i_ma)) - (DW'(i_rb) - DW'(i_mb));
        ad     = d[DW-1] ? AD'(-d) : AD'(d);
        prod   = ad * ad;
        prod_z = ZW'(prod);
        sq_sat = ((prod_z >> COST_W) != '0) ? COST_MAX : prod_z[COST_W-1:0];
    end

    // Stage two: cheapest predecessor plus the local cost, saturating.
    always_comb begin
        diag_v = r2_ctl.row0 ? '0 : r2_diag;
        best   = COST_MAX;
        have   = 1'b0;
        if (r2_ctl.diag_ok) begin
            best = diag_v;
            have = 1'b1;
        end
        if (r2_ctl.left_ok && (!have || r_left < best)) begin
            best = r_left;
            have = 1'b1;
        end
        if (r2_ctl.up_ok && (!have || r2_up < best)) begin
            best = r2_up;
        end
        sum      = {1'b0, r2_sq} + {1'b0, best};
        cost_new = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
        end else begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_col <= i_col;
        if (i_ctl.vld) begin
            r1_diag <= r_row[i_col - IW'(1)];
            r1_up   <= r_row[i_col];
        end
        r2_col  <= r1_col;
        r2_sq   <= sq_sat;
        r2_diag <= r1_diag;
        r2_up   <= r1_up;
        if (r2_ctl.vld) begin
            r_row[r2_col] <= cost_new;
            r_left        <= cost_new;
        end
    end

    assign o_cost = r_left;

endmodule
